/* rtl/core/mpmc_pkg.sv */
// shared types, constants and codes for the multi-pattern match counter
`timescale 1ns / 1ps

package mpmc_pkg;

  localparam int unsigned MaxNodes = 256;
  localparam int unsigned NodeW    = $clog2(MaxNodes);
  localparam int unsigned NodeCntW = NodeW + 1;
  localparam int unsigned ByteW    = 8;
  localparam int unsigned EdgeAw   = NodeW + ByteW;
  localparam int unsigned CntW     = 16;
  localparam int unsigned SumW     = 32;

  typedef enum logic [1:0] {
    OP_INSERT  = 2'd0,
    OP_BUILD   = 2'd1,
    OP_SCAN    = 2'd2,
    OP_RESTART = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    STATUS_OK       = 2'd0,
    STATUS_FULL     = 2'd1,
    STATUS_NO_BUILD = 2'd2
  } status_e;

  typedef enum logic [4:0] {
    ST_CLEAR, ST_IDLE, ST_DECODE,
    ST_INS_EV, ST_INS_LAST, ST_INS_OWN,
    ST_BLD_ERD, ST_BLD_ECHK, ST_BLD_WRD, ST_BLD_WCHK, ST_BLD_END, ST_BLD_ADV, ST_BLD_POP,
    ST_SC_RD, ST_SC_CHK, ST_SC_SUM,
    ST_RESULT
  } state_e;

  typedef enum logic [4:0] {
    CMD_NONE, CMD_CLEAR, CMD_LOAD,
    CMD_INS_SKIP, CMD_INS_RD, CMD_INS_STEP, CMD_INS_END, CMD_OWN_RD, CMD_OWN_INC,
    CMD_BLD_INIT, CMD_BLD_ERD, CMD_BLD_CHILD, CMD_WALK_RD, CMD_WALK_FOLLOW,
    CMD_BLD_SETFAIL, CMD_BLD_SETEND, CMD_COL_INC, CMD_Q_RD, CMD_BLD_NODE, CMD_BLD_DONE,
    CMD_SCAN_START, CMD_SCAN_REFUSE, CMD_SC_STEP, CMD_SC_SUM,
    CMD_RESTART, CMD_RESULT
  } cmd_e;

  typedef struct packed {
    cmd_e cmd;
  } ctrl_t;

  typedef struct packed {
    op_e  op;
    logic last;
    logic dropped;
    logic built;
    logic edge_nz;
    logic walk_nz;
    logic col_last;
    logic q_nonempty;
    logic clr_last;
    logic out_free;
  } stat_t;

endpackage

/* rtl/core/mpmc_ctrl.sv */
// controller state machine sequencing insert, build, scan and restart
`timescale 1ns / 1ps

module mpmc_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  mpmc_pkg::stat_t stat_i,
  output mpmc_pkg::ctrl_t ctrl_o
);

  mpmc_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= mpmc_pkg::ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    ctrl_o.cmd = mpmc_pkg::CMD_NONE;
    in_ready_o = 1'b0;
    case (state_q)
      mpmc_pkg::ST_CLEAR: begin
        ctrl_o.cmd = mpmc_pkg::CMD_CLEAR;
        if (stat_i.clr_last) state_d = mpmc_pkg::ST_IDLE;
      end
      mpmc_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          ctrl_o.cmd = mpmc_pkg::CMD_LOAD;
          state_d    = mpmc_pkg::ST_DECODE;
        end
      end
      mpmc_pkg::ST_DECODE: begin
        case (stat_i.op)
          mpmc_pkg::OP_INSERT: begin
            if (stat_i.dropped) begin
              ctrl_o.cmd = mpmc_pkg::CMD_INS_SKIP;
              state_d = stat_i.last ? mpmc_pkg::ST_INS_LAST : mpmc_pkg::ST_RESULT;
            end else begin
              ctrl_o.cmd = mpmc_pkg::CMD_INS_RD;
              state_d    = mpmc_pkg::ST_INS_EV;
            end
          end
          mpmc_pkg::OP_BUILD: begin
            ctrl_o.cmd = mpmc_pkg::CMD_BLD_INIT;
            state_d    = mpmc_pkg::ST_BLD_ERD;
          end
          mpmc_pkg::OP_SCAN: begin
            if (stat_i.built) begin
              ctrl_o.cmd = mpmc_pkg::CMD_SCAN_START;
              state_d    = mpmc_pkg::ST_SC_RD;
            end else begin
              ctrl_o.cmd = mpmc_pkg::CMD_SCAN_REFUSE;
              state_d    = mpmc_pkg::ST_RESULT;
            end
          end
          default: begin
            ctrl_o.cmd = mpmc_pkg::CMD_RESTART;
            state_d    = mpmc_pkg::ST_RESULT;
          end
        endcase
      end
      mpmc_pkg::ST_INS_EV: begin
        ctrl_o.cmd = mpmc_pkg::CMD_INS_STEP;
        state_d = stat_i.last ? mpmc_pkg::ST_INS_LAST : mpmc_pkg::ST_RESULT;
      end
      mpmc_pkg::ST_INS_LAST: begin
        if (stat_i.dropped) begin
          ctrl_o.cmd = mpmc_pkg::CMD_INS_END;
          state_d    = mpmc_pkg::ST_RESULT;
        end else begin
          ctrl_o.cmd = mpmc_pkg::CMD_OWN_RD;
          state_d    = mpmc_pkg::ST_INS_OWN;
        end
      end
      mpmc_pkg::ST_INS_OWN: begin
        ctrl_o.cmd = mpmc_pkg::CMD_OWN_INC;
        state_d    = mpmc_pkg::ST_RESULT;
      end
      mpmc_pkg::ST_BLD_ERD: begin
        ctrl_o.cmd = mpmc_pkg::CMD_BLD_ERD;
        state_d    = mpmc_pkg::ST_BLD_ECHK;
      end
      mpmc_pkg::ST_BLD_ECHK: begin
        if (stat_i.edge_nz) begin
          ctrl_o.cmd = mpmc_pkg::CMD_BLD_CHILD;
          state_d    = mpmc_pkg::ST_BLD_WRD;
        end else begin
          state_d = mpmc_pkg::ST_BLD_ADV;
        end
      end
      mpmc_pkg::ST_BLD_WRD: begin
        ctrl_o.cmd = mpmc_pkg::CMD_WALK_RD;
        state_d    = mpmc_pkg::ST_BLD_WCHK;
      end
      mpmc_pkg::ST_BLD_WCHK: begin
        if (stat_i.walk_nz && !stat_i.edge_nz) begin
          ctrl_o.cmd = mpmc_pkg::CMD_WALK_FOLLOW;
          state_d    = mpmc_pkg::ST_BLD_WRD;
        end else begin
          ctrl_o.cmd = mpmc_pkg::CMD_BLD_SETFAIL;
          state_d    = mpmc_pkg::ST_BLD_END;
        end
      end
      mpmc_pkg::ST_BLD_END: begin
        ctrl_o.cmd = mpmc_pkg::CMD_BLD_SETEND;
        state_d    = mpmc_pkg::ST_BLD_ADV;
      end
      mpmc_pkg::ST_BLD_ADV: begin
        if (!stat_i.col_last) begin
          ctrl_o.cmd = mpmc_pkg::CMD_COL_INC;
          state_d    = mpmc_pkg::ST_BLD_ERD;
        end else if (stat_i.q_nonempty) begin
          ctrl_o.cmd = mpmc_pkg::CMD_Q_RD;
          state_d    = mpmc_pkg::ST_BLD_POP;
        end else begin
          ctrl_o.cmd = mpmc_pkg::CMD_BLD_DONE;
          state_d    = mpmc_pkg::ST_RESULT;
        end
      end
      mpmc_pkg::ST_BLD_POP: begin
        ctrl_o.cmd = mpmc_pkg::CMD_BLD_NODE;
        state_d    = mpmc_pkg::ST_BLD_ERD;
      end
      mpmc_pkg::ST_SC_RD: begin
        ctrl_o.cmd = mpmc_pkg::CMD_WALK_RD;
        state_d    = mpmc_pkg::ST_SC_CHK;
      end
      mpmc_pkg::ST_SC_CHK: begin
        if (stat_i.walk_nz && !stat_i.edge_nz) begin
          ctrl_o.cmd = mpmc_pkg::CMD_WALK_FOLLOW;
          state_d    = mpmc_pkg::ST_SC_RD;
        end else begin
          ctrl_o.cmd = mpmc_pkg::CMD_SC_STEP;
          state_d    = mpmc_pkg::ST_SC_SUM;
        end
      end
      mpmc_pkg::ST_SC_SUM: begin
        ctrl_o.cmd = mpmc_pkg::CMD_SC_SUM;
        state_d    = mpmc_pkg::ST_RESULT;
      end
      mpmc_pkg::ST_RESULT: begin
        if (stat_i.out_free) begin
          ctrl_o.cmd = mpmc_pkg::CMD_RESULT;
          state_d    = mpmc_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = mpmc_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

/* rtl/core/mpmc_dp.sv */
// datapath: trie memories, failure-link walker, counters and output register
`timescale 1ns / 1ps

module mpmc_dp (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  mpmc_pkg::ctrl_t               ctrl_i,
  output mpmc_pkg::stat_t               stat_o,
  input  logic [1:0]                    in_op_i,
  input  logic [mpmc_pkg::ByteW-1:0]    in_byte_i,
  input  logic                          in_last_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [1:0]                    out_status_o,
  output logic [mpmc_pkg::CntW-1:0]     out_matches_o,
  output logic [mpmc_pkg::SumW-1:0]     out_sum_o
);

  localparam int unsigned NW = mpmc_pkg::NodeW;
  localparam int unsigned CW = mpmc_pkg::CntW;
  localparam int unsigned SW = mpmc_pkg::SumW;
  localparam int unsigned AW = mpmc_pkg::EdgeAw;

  // memories
  logic [NW-1:0] edge_mem  [2**AW];
  logic [NW-1:0] fail_mem  [mpmc_pkg::MaxNodes];
  logic [CW-1:0] own_mem   [mpmc_pkg::MaxNodes];
  logic [CW-1:0] end_mem   [mpmc_pkg::MaxNodes];
  logic [NW-1:0] queue_mem [mpmc_pkg::MaxNodes];

  logic [NW-1:0] edge_rd_q, fail_rd_q, queue_rd_q;
  logic [CW-1:0] own_rd_q, end_rd_q;

  logic [AW-1:0] edge_addr;
  logic [NW-1:0] edge_wd, fail_addr, fail_wd, cnt_addr_own, cnt_addr_end, q_addr;
  logic [CW-1:0] own_wd, end_wd;
  logic          edge_we, edge_re, fail_we, fail_re, own_we, own_re, end_we, end_re;
  logic          q_we, q_re;

  // control state
  mpmc_pkg::op_e         op_q;
  logic [mpmc_pkg::ByteW-1:0] byte_q;
  logic                  last_q;
  logic [mpmc_pkg::NodeCntW-1:0] node_used_q, head_q, tail_q;
  logic [NW-1:0]         cursor_q, scan_node_q, bnode_q, walk_q, child_q;
  logic [mpmc_pkg::ByteW-1:0] col_q;
  logic                  dropped_q, built_q;
  logic [SW-1:0]         sum_q;
  logic [AW-1:0]         clr_q;
  logic [1:0]            res_status_q;
  logic [CW-1:0]         res_matches_q;
  logic                  out_valid_q;
  logic [1:0]            out_status_q;
  logic [CW-1:0]         out_matches_q;
  logic [SW-1:0]         out_sum_q;

  logic                  edge_nz, table_full;
  logic [NW-1:0]         fail_new, scan_st;
  logic [CW:0]           own_inc, end_add;
  logic [SW:0]           sum_add;

  assign edge_nz    = (edge_rd_q != '0);
  assign table_full = (node_used_q == mpmc_pkg::NodeCntW'(mpmc_pkg::MaxNodes));
  assign fail_new   = (edge_nz && (edge_rd_q != child_q)) ? edge_rd_q : '0;
  assign scan_st    = edge_nz ? edge_rd_q : walk_q;
  assign own_inc    = {1'b0, own_rd_q} + (CW+1)'(1);
  assign end_add    = {1'b0, own_rd_q} + {1'b0, end_rd_q};
  assign sum_add    = {1'b0, sum_q} + (SW+1)'(end_rd_q);

  always_comb begin
    edge_addr    = {walk_q, col_q};
    edge_wd      = '0;
    edge_we      = 1'b0;
    edge_re      = 1'b0;
    fail_addr    = walk_q;
    fail_wd      = '0;
    fail_we      = 1'b0;
    fail_re      = 1'b0;
    cnt_addr_own = cursor_q;
    cnt_addr_end = child_q;
    own_wd       = '0;
    end_wd       = '0;
    own_we       = 1'b0;
    own_re       = 1'b0;
    end_we       = 1'b0;
    end_re       = 1'b0;
    q_addr       = tail_q[NW-1:0];
    q_we         = 1'b0;
    q_re         = 1'b0;
    case (ctrl_i.cmd)
      mpmc_pkg::CMD_CLEAR: begin
        edge_addr    = clr_q;
        edge_we      = 1'b1;
        cnt_addr_own = clr_q[NW-1:0];
        cnt_addr_end = clr_q[NW-1:0];
        own_we       = (clr_q[AW-1:NW] == '0);
        end_we       = (clr_q[AW-1:NW] == '0);
      end
      mpmc_pkg::CMD_INS_RD: begin
        edge_addr = {cursor_q, byte_q};
        edge_re   = 1'b1;
      end
      mpmc_pkg::CMD_INS_STEP: begin
        edge_addr = {cursor_q, byte_q};
        edge_wd   = node_used_q[NW-1:0];
        edge_we   = !edge_nz && !table_full;
      end
      mpmc_pkg::CMD_OWN_RD: begin
        own_re = 1'b1;
      end
      mpmc_pkg::CMD_OWN_INC: begin
        own_we = 1'b1;
        own_wd = own_inc[CW] ? '1 : own_inc[CW-1:0];
      end
      mpmc_pkg::CMD_BLD_INIT: begin
        fail_addr = '0;
        fail_we   = 1'b1;
      end
      mpmc_pkg::CMD_BLD_ERD: begin
        edge_addr = {bnode_q, col_q};
        edge_re   = 1'b1;
        fail_addr = bnode_q;
        fail_re   = 1'b1;
      end
      mpmc_pkg::CMD_WALK_RD: begin
        edge_re = 1'b1;
        fail_re = 1'b1;
      end
      mpmc_pkg::CMD_BLD_SETFAIL: begin
        fail_addr    = child_q;
        fail_wd      = fail_new;
        fail_we      = 1'b1;
        cnt_addr_end = fail_new;
        end_re       = 1'b1;
        cnt_addr_own = child_q;
        own_re       = 1'b1;
      end
      mpmc_pkg::CMD_BLD_SETEND: begin
        end_we = 1'b1;
        end_wd = end_add[CW] ? '1 : end_add[CW-1:0];
        q_we   = !tail_q[NW];
      end
      mpmc_pkg::CMD_Q_RD: begin
        q_addr = head_q[NW-1:0];
        q_re   = 1'b1;
      end
      mpmc_pkg::CMD_SC_STEP: begin
        cnt_addr_end = scan_st;
        end_re       = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (edge_we) edge_mem[edge_addr] <= edge_wd;
    if (edge_re) edge_rd_q <= edge_mem[edge_addr];
  end

  always_ff @(posedge clk_i) begin
    if (fail_we) fail_mem[fail_addr] <= fail_wd;
    if (fail_re) fail_rd_q <= fail_mem[fail_addr];
  end

  always_ff @(posedge clk_i) begin
    if (own_we) own_mem[cnt_addr_own] <= own_wd;
    if (own_re) own_rd_q <= own_mem[cnt_addr_own];
  end

  always_ff @(posedge clk_i) begin
    if (end_we) end_mem[cnt_addr_end] <= end_wd;
    if (end_re) end_rd_q <= end_mem[cnt_addr_end];
  end

  always_ff @(posedge clk_i) begin
    if (q_we) queue_mem[q_addr] <= child_q;
    if (q_re) queue_rd_q <= queue_mem[q_addr];
  end

  // captured item, build node/column/child registers and result payload
  always_ff @(posedge clk_i) begin
    case (ctrl_i.cmd)
      mpmc_pkg::CMD_LOAD: begin
        op_q          <= mpmc_pkg::op_e'(in_op_i);
        byte_q        <= in_byte_i;
        last_q        <= in_last_i;
        res_status_q  <= mpmc_pkg::STATUS_OK;
        res_matches_q <= '0;
      end
      mpmc_pkg::CMD_INS_SKIP: res_status_q <= mpmc_pkg::STATUS_FULL;
      mpmc_pkg::CMD_INS_STEP: begin
        if (!edge_nz && table_full) res_status_q <= mpmc_pkg::STATUS_FULL;
      end
      mpmc_pkg::CMD_SCAN_REFUSE: res_status_q <= mpmc_pkg::STATUS_NO_BUILD;
      mpmc_pkg::CMD_SC_SUM:      res_matches_q <= end_rd_q;
      mpmc_pkg::CMD_BLD_CHILD:   child_q <= edge_rd_q;
      mpmc_pkg::CMD_BLD_INIT: begin
        bnode_q <= '0;
        col_q   <= '0;
      end
      mpmc_pkg::CMD_BLD_NODE: begin
        bnode_q <= queue_rd_q;
        col_q   <= '0;
      end
      mpmc_pkg::CMD_COL_INC:    col_q <= col_q + mpmc_pkg::ByteW'(1);
      mpmc_pkg::CMD_SCAN_START: col_q <= byte_q;
      default: begin
      end
    endcase
    if (ctrl_i.cmd == mpmc_pkg::CMD_RESULT) begin
      out_status_q  <= res_status_q;
      out_matches_q <= res_matches_q;
      out_sum_q     <= sum_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      node_used_q <= mpmc_pkg::NodeCntW'(1);
      cursor_q    <= '0;
      scan_node_q <= '0;
      walk_q      <= '0;
      dropped_q   <= 1'b0;
      built_q     <= 1'b0;
      sum_q       <= '0;
      clr_q       <= '0;
      head_q      <= '0;
      tail_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (ctrl_i.cmd == mpmc_pkg::CMD_RESULT) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (ctrl_i.cmd)
        mpmc_pkg::CMD_CLEAR: clr_q <= clr_q + AW'(1);
        mpmc_pkg::CMD_INS_SKIP: built_q <= 1'b0;
        mpmc_pkg::CMD_INS_STEP: begin
          built_q <= 1'b0;
          if (edge_nz) begin
            cursor_q <= edge_rd_q;
          end else if (table_full) begin
            dropped_q <= 1'b1;
          end else begin
            cursor_q    <= node_used_q[NW-1:0];
            node_used_q <= node_used_q + mpmc_pkg::NodeCntW'(1);
          end
        end
        mpmc_pkg::CMD_INS_END, mpmc_pkg::CMD_OWN_INC: begin
          cursor_q  <= '0;
          dropped_q <= 1'b0;
        end
        mpmc_pkg::CMD_BLD_INIT: begin
          head_q <= '0;
          tail_q <= '0;
        end
        mpmc_pkg::CMD_BLD_CHILD, mpmc_pkg::CMD_WALK_FOLLOW: walk_q <= fail_rd_q;
        mpmc_pkg::CMD_BLD_SETEND: begin
          if (!tail_q[NW]) tail_q <= tail_q + mpmc_pkg::NodeCntW'(1);
        end
        mpmc_pkg::CMD_Q_RD:     head_q <= head_q + mpmc_pkg::NodeCntW'(1);
        mpmc_pkg::CMD_BLD_DONE: built_q <= 1'b1;
        mpmc_pkg::CMD_SCAN_START: walk_q <= scan_node_q;
        mpmc_pkg::CMD_SC_STEP:  scan_node_q <= scan_st;
        mpmc_pkg::CMD_SC_SUM:   sum_q <= sum_add[SW] ? '1 : sum_add[SW-1:0];
        mpmc_pkg::CMD_RESTART: begin
          scan_node_q <= '0;
          sum_q       <= '0;
        end
        default: begin
        end
      endcase
    end
  end

  assign stat_o.op         = op_q;
  assign stat_o.last       = last_q;
  assign stat_o.dropped    = dropped_q;
  assign stat_o.built      = built_q;
  assign stat_o.edge_nz    = edge_nz;
  assign stat_o.walk_nz    = (walk_q != '0);
  assign stat_o.col_last   = (col_q == '1);
  assign stat_o.q_nonempty = (head_q < tail_q);
  assign stat_o.clr_last   = (clr_q == '1);
  assign stat_o.out_free   = !out_valid_q || out_ready_i;

  assign out_valid_o   = out_valid_q;
  assign out_status_o  = out_status_q;
  assign out_matches_o = out_matches_q;
  assign out_sum_o     = out_sum_q;

  a_node_used_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    node_used_q != '0 && node_used_q <= mpmc_pkg::NodeCntW'(mpmc_pkg::MaxNodes))
    else $error("node count out of range");

  a_cursor_allocated: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mpmc_pkg::NodeCntW'(cursor_q) < node_used_q)
    else $error("insert cursor points at an unallocated node");

  a_restart_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_i.cmd == mpmc_pkg::CMD_RESTART |=> sum_q == '0 && scan_node_q == '0)
    else $error("restart did not clear scan state");

  a_queue_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    head_q <= tail_q)
    else $error("bfs queue read past its tail");

endmodule

/* rtl/core/multi_pattern_match_counter.sv */
// top level of the multi-pattern match counter (trie insert, failure-link build, scan)
`timescale 1ns / 1ps

// channel   | direction | tdata                          | tuser       | tlast
// s_axis    | in        | [7:0] data_byte                | [1:0] opcode| last_byte
// m_axis    | out       | [15:0] matches_here, [47:16] match_sum | [1:0] status | -
//
// one transfer in gives exactly one transfer out, in order
// insert follows or adds one trie edge per byte, scan follows failure links until an
// edge is found or the root is reached, and build visits every (node, byte) slot of
// every reached node in turn through the single port of the edge memory
// after reset a clearing pass sweeps the 65536-entry edge memory, one entry a cycle,
// before the first transfer is taken
// a new item is taken while the previous result waits in the output register

module multi_pattern_match_counter (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] data_byte
  input  logic [1:0]  s_axis_tuser_i,   // [1:0] opcode
  input  logic        s_axis_tlast_i,   // last_byte
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [47:0] m_axis_tdata_o,   // [15:0] matches_here, [47:16] match_sum
  output logic [1:0]  m_axis_tuser_o    // [1:0] status
);

  mpmc_pkg::ctrl_t ctrl;
  mpmc_pkg::stat_t stat;
  logic [mpmc_pkg::CntW-1:0] match_cnt;
  logic [mpmc_pkg::SumW-1:0] sum;

  // sequencer: one state per memory access step
  mpmc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .stat_i     (stat),
    .ctrl_o     (ctrl)
  );

  // memories, walker registers and output register
  mpmc_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .ctrl_i        (ctrl),
    .stat_o        (stat),
    .in_op_i       (s_axis_tuser_i),
    .in_byte_i     (s_axis_tdata_i),
    .in_last_i     (s_axis_tlast_i),
    .out_valid_o   (m_axis_tvalid_o),
    .out_ready_i   (m_axis_tready_i),
    .out_status_o  (m_axis_tuser_o),
    .out_matches_o (match_cnt),
    .out_sum_o     (sum)
  );

  assign m_axis_tdata_o = {sum, match_cnt};

endmodule
